[src/fxa_pkg.sv]
`timescale 1ns / 1ps

package fxa_pkg;

    localparam int FIELD_W        = 32;
    localparam int OP_W           = 4;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int WORD_WIDTH_DEF = 32;
    // quotient bits resolved in each divider stage
    localparam int DIV_STEPS      = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } t_op;

    // everything a request carries past the divider besides the quotient
    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] res;
        logic               flag;
        logic               err;
        logic               neg;
    } t_side;

    typedef struct packed {
        logic  valid;
        t_side side;
    } t_lane;

endpackage

[src/fxa_req_if.sv]
`timescale 1ns / 1ps

interface fxa_req_if import fxa_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           req_type;
    logic signed [FIELD_W-1:0] operand_a;
    logic signed [FIELD_W-1:0] operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink (input valid, req_type, operand_a, operand_b, output ready);

endinterface

[src/fxa_rsp_if.sv]
`timescale 1ns / 1ps

interface fxa_rsp_if import fxa_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] result_word;
    logic                      compare_flag;
    logic                      divide_error;

    modport source (output valid, result_word, compare_flag, divide_error, input ready);
    modport sink (input valid, result_word, compare_flag, divide_error, output ready);

endinterface

[src/fixed_point_alu.sv]
`timescale 1ns / 1ps

// Channel   Dir  Fields                                  Handshake
// i_req     in   req_type[4], operand_a[32], operand_b[32] valid / ready
// o_rsp     out  result_word[32], compare_flag, divide_error valid / ready
//
// One request per cycle while o_rsp accepts responses; back-pressure stalls the pipeline.
// The restoring divider resolves four quotient bits per stage.
// Every opcode travels the same stages, so responses leave in request order.
// Reset (synchronous, active low) clears the valid bits only; no clearing pass.
// Each stage holds its request while the stage after it is full and stalled.

module fixed_point_alu import fxa_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fxa_req_if.sink       i_req,
    fxa_rsp_if.source     o_rsp
);

    localparam int OW = (WORD_WIDTH < FIELD_W) ? WORD_WIDTH : FIELD_W;

    // wrap to the working width, then sign-extend to the field width
    function automatic logic [FIELD_W-1:0] fit(input logic [FIELD_W-1:0] x);
        logic [FIELD_W-1:0] y;
        for (int i = 0; i < FIELD_W; i++) begin
            y[i] = (i < OW) ? x[i] : x[OW-1];
        end
        return y;
    endfunction

    logic w_en_a, w_en_b, w_en_c, w_en_out, w_div_ready;

    // stage A: operand capture
    logic               r_a_valid;
    t_op                r_a_op;
    logic [FIELD_W-1:0] r_a_a, r_a_b;

    // stage B: simple results, product, divider set-up
    logic                      r_b_valid;
    t_side                     r_b_side;
    logic signed [2*FIELD_W-1:0] r_b_prod;
    logic [FIELD_W-1:0]        r_b_mag_a, r_b_mag_b;

    // stage C: product scaling
    logic               r_c_valid;
    t_side              r_c_side;
    t_side              n_c_side;
    t_lane              w_c_lane;
    logic [FIELD_W-1:0] r_c_mag_a, r_c_mag_b;

    // output register
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_res;
    logic               r_out_flag, r_out_err;

    t_lane              w_div_lane;
    logic [FIELD_W-1:0] w_div_quot;

    assign w_en_out = !r_out_valid || o_rsp.ready;
    assign w_en_c   = !r_c_valid || w_div_ready;
    assign w_en_b   = !r_b_valid || w_en_c;
    assign w_en_a   = !r_a_valid || w_en_b;
    assign i_req.ready = w_en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en_a) begin
            r_a_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_op <= t_op'(i_req.req_type);
            r_a_a  <= fit(i_req.operand_a);
            r_a_b  <= fit(i_req.operand_b);
        end
    end

    t_side              n_b_side;
    logic [FIELD_W-1:0] w_sum, w_diff, w_inc, w_dec;
    logic               w_lt, w_gt, w_eq;

    assign w_sum  = r_a_a + r_a_b;
    assign w_diff = r_a_a - r_a_b;
    assign w_inc  = r_a_a + 1'b1;
    assign w_dec  = r_a_a - 1'b1;
    assign w_lt   = $signed(r_a_a) < $signed(r_a_b);
    assign w_gt   = $signed(r_a_b) < $signed(r_a_a);
    assign w_eq   = (r_a_a == r_a_b);

    always_comb begin
        n_b_side     = '0;
        n_b_side.op  = r_a_op;
        n_b_side.neg = r_a_a[FIELD_W-1] ^ r_a_b[FIELD_W-1];
        case (r_a_op)
            OP_ADD:      n_b_side.res  = fit(w_sum);
            OP_SUB:      n_b_side.res  = fit(w_diff);
            OP_MUL:      n_b_side.res  = '0;
            OP_DIV:      n_b_side.err  = (r_a_b == '0);
            OP_GT:       n_b_side.flag = w_gt;
            OP_LT:       n_b_side.flag = w_lt;
            OP_GE:       n_b_side.flag = !w_lt;
            OP_LE:       n_b_side.flag = !w_gt;
            OP_EQ:       n_b_side.flag = w_eq;
            OP_NE:       n_b_side.flag = !w_eq;
            OP_MIN:      n_b_side.res  = w_lt ? r_a_a : r_a_b;
            OP_MAX:      n_b_side.res  = w_gt ? r_a_a : r_a_b;
            OP_INC:      n_b_side.res  = fit(w_inc);
            OP_DEC:      n_b_side.res  = fit(w_dec);
            OP_FROM_INT: n_b_side.res  = fit(r_a_a << FRAC_BITS);
            OP_TO_INT:   n_b_side.res  = fit(FIELD_W'($signed(r_a_a) >>> FRAC_BITS));
            default:     n_b_side.res  = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_side  <= n_b_side;
            r_b_prod  <= $signed(r_a_a) * $signed(r_a_b);
            r_b_mag_a <= r_a_a[FIELD_W-1] ? (~r_a_a + 1'b1) : r_a_a;
            r_b_mag_b <= r_a_b[FIELD_W-1] ? (~r_a_b + 1'b1) : r_a_b;
        end
    end

    always_comb begin
        n_c_side = r_b_side;
        if (r_b_side.op == OP_MUL) begin
            n_c_side.res = fit(r_b_prod[FRAC_BITS +: FIELD_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_c_side  <= n_c_side;
            r_c_mag_a <= r_b_mag_a;
            r_c_mag_b <= r_b_mag_b;
        end
    end

    assign w_c_lane = '{valid: r_c_valid, side: r_c_side};

    fxa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lane     (w_c_lane),
        .i_dividend (r_c_mag_a),
        .i_divisor  (r_c_mag_b),
        .o_ready    (w_div_ready),
        .i_adv      (w_en_out),
        .o_lane     (w_div_lane),
        .o_quot     (w_div_quot)
    );

    logic [FIELD_W-1:0] n_out_res;

    always_comb begin
        n_out_res = w_div_lane.side.res;
        if (w_div_lane.side.op == OP_DIV) begin
            if (w_div_lane.side.err) begin
                n_out_res = '0;
            end else if (w_div_lane.side.neg) begin
                n_out_res = fit(~w_div_quot + 1'b1);
            end else begin
                n_out_res = fit(w_div_quot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= w_div_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_res  <= n_out_res;
            r_out_flag <= w_div_lane.side.flag;
            r_out_err  <= w_div_lane.side.err;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_word  = r_out_res;
    assign o_rsp.compare_flag = r_out_flag;
    assign o_rsp.divide_error = r_out_err;

`ifndef ASSERT_OFF
    a_err_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.divide_error |-> o_rsp.result_word == '0)
        else $error("divide error with non-zero result");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.compare_flag && o_rsp.divide_error))
        else $error("compare flag and divide error both set");

    a_flag_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.compare_flag |-> o_rsp.result_word == '0)
        else $error("comparison with non-zero result word");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.valid |-> i_req.ready)
        else $error("request stalled with empty output register");
`endif

endmodule

[src/fxa_div.sv]
`timescale 1ns / 1ps

module fxa_div import fxa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane              i_lane,
    input  logic [FIELD_W-1:0] i_dividend,
    input  logic [FIELD_W-1:0] i_divisor,
    output logic               o_ready,
    input  logic               i_adv,
    output t_lane              o_lane,
    output logic [FIELD_W-1:0] o_quot
);

    localparam int DW = FIELD_W + FRAC_BITS;
    localparam int NS = (DW + DIV_STEPS - 1) / DIV_STEPS;

    logic               r_valid [NS];
    t_side              r_side [NS];
    logic [DW-1:0]      r_work [NS];
    logic [FIELD_W-1:0] r_rem  [NS];
    logic [FIELD_W-1:0] r_dvs  [NS];

    logic               w_en  [NS];
    logic               w_vin [NS];
    t_side              w_side_in [NS];
    logic [DW-1:0]      w_work_in [NS];
    logic [FIELD_W-1:0] w_rem_in  [NS];
    logic [FIELD_W-1:0] w_dvs_in  [NS];
    logic [DW-1:0]      n_work    [NS];
    logic [FIELD_W-1:0] n_rem     [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_vin[s]     = i_lane.valid;
            assign w_side_in[s] = i_lane.side;
            assign w_work_in[s] = {i_dividend, {FRAC_BITS{1'b0}}};
            assign w_rem_in[s]  = '0;
            assign w_dvs_in[s]  = i_divisor;
        end else begin : g_next
            assign w_vin[s]     = r_valid[s-1];
            assign w_side_in[s] = r_side[s-1];
            assign w_work_in[s] = r_work[s-1];
            assign w_rem_in[s]  = r_rem[s-1];
            assign w_dvs_in[s]  = r_dvs[s-1];
        end

        if (s == NS - 1) begin : g_last_en
            assign w_en[s] = !r_valid[s] || i_adv;
        end else begin : g_mid_en
            assign w_en[s] = !r_valid[s] || w_en[s+1];
        end

        // restoring division: shift in a dividend bit, subtract when it fits
        always_comb begin
            logic [FIELD_W:0]   sh;
            logic [DW-1:0]      w;
            logic [FIELD_W-1:0] rm;
            logic               qb;
            sh = '0;
            qb = 1'b0;
            w  = w_work_in[s];
            rm = w_rem_in[s];
            for (int k = 0; k < DIV_STEPS; k++) begin
                if (s * DIV_STEPS + k < DW) begin
                    sh = {rm, w[DW-1]};
                    qb = (sh >= {1'b0, w_dvs_in[s]});
                    if (qb) begin
                        sh = sh - {1'b0, w_dvs_in[s]};
                    end
                    rm = sh[FIELD_W-1:0];
                    w  = {w[DW-2:0], qb};
                end
            end
            n_work[s] = w;
            n_rem[s]  = rm;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_valid[s] <= w_vin[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_side[s] <= w_side_in[s];
                r_work[s] <= n_work[s];
                r_rem[s]  <= n_rem[s];
                r_dvs[s]  <= w_dvs_in[s];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_lane  = '{valid: r_valid[NS-1], side: r_side[NS-1]};
    assign o_quot  = r_work[NS-1][FIELD_W-1:0];

endmodule

[test/fixed_point_alu_tb.sv]
`timescale 1ns / 1ps

module fixed_point_alu_tb;
    import fxa_pkg::*;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int LATENCY  = 4 + (32 + FRAC + 3) / 4;
    localparam int N_RANDOM = 500;

    localparam logic signed [FIELD_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    typedef struct {
        t_op                       op;
        logic signed [FIELD_W-1:0] a;
        logic signed [FIELD_W-1:0] b;
    } t_alu_request;

    typedef struct packed {
        logic [FIELD_W-1:0] word;
        logic               flag;
        logic               err;
    } t_alu_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fxa_req_if req_bus ();
    fxa_rsp_if rsp_bus ();

    fixed_point_alu uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #2 i_clk = ~i_clk;

    t_alu_request request_queue[$];
    t_alu_answer  expected_answers[$];
    t_alu_answer  got_answer;
    t_alu_answer  want_answer;
    int           mismatch_count = 0;
    int           send_gap = 0;
    int           stall_left = 0;
    logic         send_calm = 1'b0;
    logic         recv_calm = 1'b0;

    // Q24.8 behaviour at 32 bits; wide intermediates hold the full product and quotient
    function automatic t_alu_answer alu_result(t_op op, logic signed [FIELD_W-1:0] a,
                                               logic signed [FIELD_W-1:0] b);
        logic signed [63:0] wide_a;
        logic signed [63:0] wide_b;
        logic signed [63:0] prod;
        logic [63:0]        mag_a;
        logic [63:0]        mag_b;
        logic [63:0]        quot;
        t_alu_answer        r;
        wide_a = a;
        wide_b = b;
        r = '0;
        case (op)
            OP_ADD: r.word = a + b;
            OP_SUB: r.word = a - b;
            OP_MUL: begin
                prod = wide_a * wide_b;
                r.word = FIELD_W'(prod >>> FRAC);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.err = 1'b1;
                end else begin
                    mag_a = a[FIELD_W-1] ? -wide_a : wide_a;
                    mag_b = b[FIELD_W-1] ? -wide_b : wide_b;
                    quot = (mag_a << FRAC) / mag_b;
                    r.word = FIELD_W'((a[FIELD_W-1] ^ b[FIELD_W-1]) ? -quot : quot);
                end
            end
            OP_GT: r.flag = a > b;
            OP_LT: r.flag = a < b;
            OP_GE: r.flag = a >= b;
            OP_LE: r.flag = a <= b;
            OP_EQ: r.flag = a == b;
            OP_NE: r.flag = a != b;
            OP_MIN: r.word = (a < b) ? a : b;
            OP_MAX: r.word = (b < a) ? a : b;
            OP_INC: r.word = a + 32'sd1;
            OP_DEC: r.word = a - 32'sd1;
            OP_FROM_INT: r.word = a << FRAC;
            default: r.word = a >>> FRAC;
        endcase
        return r;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic signed [FIELD_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            4, 5: return int'($urandom_range(0, 4095)) - 2048;
            6: begin
                case ($urandom_range(0, 4))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            // whole numbers, so products of two of them land on round values
            7: return (int'($urandom_range(0, 255)) - 128) <<< FRAC;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(t_op op, logic signed [FIELD_W-1:0] a,
                                 logic signed [FIELD_W-1:0] b);
        t_alu_request item;
        item.op = op;
        item.a  = a;
        item.b  = b;
        request_queue.push_back(item);
    endtask

    // Driver: predict on acceptance, then present the next request after its gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid     <= 1'b0;
            req_bus.req_type  <= OP_ADD;
            req_bus.operand_a <= '0;
            req_bus.operand_b <= '0;
        end else begin
            if (req_bus.valid && req_bus.ready)
                expected_answers.push_back(alu_result(t_op'(req_bus.req_type),
                                                      req_bus.operand_a, req_bus.operand_b));
            if ($urandom_range(0, 99) == 0)
                send_calm <= !send_calm;
            if (!req_bus.valid || req_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    req_bus.valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    req_bus.valid     <= 1'b1;
                    req_bus.req_type  <= request_queue[0].op;
                    req_bus.operand_a <= request_queue[0].a;
                    req_bus.operand_b <= request_queue[0].b;
                    void'(request_queue.pop_front());
                    if (send_calm || $urandom_range(0, 1) == 0)
                        send_gap <= 0;
                    else
                        send_gap <= gap_length();
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and in-order comparison of responses
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                got_answer.word = rsp_bus.result_word;
                got_answer.flag = rsp_bus.compare_flag;
                got_answer.err  = rsp_bus.divide_error;
                if (expected_answers.size() == 0) begin
                    $display("%0t: response with none expected: word %h flag %b err %b",
                             $time, got_answer.word, got_answer.flag, got_answer.err);
                    mismatch_count++;
                end else begin
                    want_answer = expected_answers.pop_front();
                    if (got_answer.word !== want_answer.word) begin
                        $display("%0t: result_word expected %h actual %h",
                                 $time, want_answer.word, got_answer.word);
                        mismatch_count++;
                    end
                    if (got_answer.flag !== want_answer.flag) begin
                        $display("%0t: compare_flag expected %b actual %b",
                                 $time, want_answer.flag, got_answer.flag);
                        mismatch_count++;
                    end
                    if (got_answer.err !== want_answer.err) begin
                        $display("%0t: divide_error expected %b actual %b",
                                 $time, want_answer.err, got_answer.err);
                        mismatch_count++;
                    end
                end
            end
            if ($urandom_range(0, 99) == 0)
                recv_calm <= !recv_calm;
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                rsp_bus.ready <= 1'b0;
            end else if (!recv_calm && $urandom_range(0, 5) == 0) begin
                stall_left <= gap_length() - 1;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic signed [FIELD_W-1:0] a;
        logic signed [FIELD_W-1:0] b;
        t_op                       op;

        i_rst_n = 1'b0;

        // directed: wrap-around, divide by zero, the most negative operand, every opcode
        queue_request(OP_ADD, MOST_POS, 1);
        queue_request(OP_SUB, MOST_NEG, 1);
        queue_request(OP_MUL, MOST_POS, MOST_POS);
        queue_request(OP_MUL, MOST_NEG, MOST_NEG);
        queue_request(OP_MUL, MOST_NEG, -1);
        queue_request(OP_MUL, 32'sh100, -32'sh180);
        queue_request(OP_DIV, 32'sh500, 0);
        queue_request(OP_DIV, MOST_NEG, -1);
        queue_request(OP_DIV, MOST_POS, 1);
        queue_request(OP_DIV, -32'sh300, 32'sh200);
        queue_request(OP_GT, MOST_POS, MOST_NEG);
        queue_request(OP_LT, MOST_NEG, MOST_POS);
        queue_request(OP_GE, 5, 5);
        queue_request(OP_LE, -5, -5);
        queue_request(OP_EQ, MOST_NEG, MOST_NEG);
        queue_request(OP_NE, 0, -1);
        queue_request(OP_MIN, MOST_NEG, MOST_POS);
        queue_request(OP_MAX, MOST_NEG, MOST_POS);
        queue_request(OP_INC, MOST_POS, $urandom);
        queue_request(OP_DEC, MOST_NEG, $urandom);
        queue_request(OP_FROM_INT, 32'sh0080_0000, $urandom);
        queue_request(OP_FROM_INT, -1, MOST_NEG);
        queue_request(OP_TO_INT, MOST_NEG, MOST_POS);
        queue_request(OP_TO_INT, -1, 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            op = t_op'($urandom_range(0, 15));
            a  = pick_operand();
            b  = ($urandom_range(0, 7) == 0) ? a : pick_operand();
            if (op == OP_DIV && $urandom_range(0, 9) == 0)
                b = 0;
            queue_request(op, a, b);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() > 0 || req_bus.valid || expected_answers.size() > 0)
            @(posedge i_clk);
        // hold a little longer so a stray extra response is still caught
        repeat (LATENCY + 10) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("[fixed_point_alu] OK");
        else
            $display("[fixed_point_alu] ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[fixed_point_alu] ERROR");
        $finish;
    end

endmodule
